/* design/tms_pkg.sv */
// Shared types and codes for the triangle mesh point split block.
// No dependencies; imported by every module of the block.
package tms_pkg;

    localparam int VERTEX_DEPTH_DEF   = 4096;
    localparam int TRIANGLE_DEPTH_DEF = 8192;
    localparam int EDGE_DEPTH_DEF     = 16384;

    localparam logic [14:0] NONE_REF = 15'd16384;

    // input item kinds
    localparam logic [2:0] KIND_VERTEX     = 3'd0;
    localparam logic [2:0] KIND_TRI_CORNER = 3'd1;
    localparam logic [2:0] KIND_TRI_EDGE   = 3'd2;
    localparam logic [2:0] KIND_EDGE_END   = 3'd3;
    localparam logic [2:0] KIND_EDGE_TRI   = 3'd4;
    localparam logic [2:0] KIND_SET_COUNTS = 3'd5;
    localparam logic [2:0] KIND_SPLIT      = 3'd6;

    // record kinds
    localparam logic [2:0] REC_ACK        = 3'd0;
    localparam logic [2:0] REC_VERTEX     = 3'd1;
    localparam logic [2:0] REC_TRI_CORNER = 3'd2;
    localparam logic [2:0] REC_TRI_EDGE   = 3'd3;
    localparam logic [2:0] REC_EDGE_END   = 3'd4;
    localparam logic [2:0] REC_EDGE_TRI   = 3'd5;
    localparam logic [2:0] REC_ERROR      = 3'd6;

    // configuration register indexes
    localparam logic CFG_BARY_U = 1'b0;
    localparam logic CFG_BARY_V = 1'b1;

    localparam logic [16:0] BARY_RESET = 17'd21845;

    typedef struct packed {
        logic [2:0]         kind;
        logic [13:0]        entry_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [14:0]        ref_first;
        logic [14:0]        ref_second;
        logic [14:0]        ref_third;
        logic [15:0]        color;
    } in_t;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic [13:0]        record_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [14:0]        out_ref_first;
        logic [14:0]        out_ref_second;
        logic [14:0]        out_ref_third;
        logic [15:0]        out_color;
        logic               last;
    } out_t;

    // table port strobes
    typedef struct packed {
        logic vtx_we;
        logic vtx_re;
        logic tri_we;
        logic tri_re;
        logic tedg_we;
        logic tedg_re;
        logic eend_we;
        logic eend_re;
        logic etri_we;
        logic etri_re;
    } tbl_ctl_t;

endpackage

/* design/tms_blend.sv */
// Barycentric blend unit: one weighted corner per call, accumulated.
// Depends on tms_pkg (nothing used beyond the import convention).
module tms_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               in_valid,
    input  logic [16:0]        weight,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z
);
    import tms_pkg::*;

    logic signed [49:0] px_reg, py_reg, pz_reg;
    logic signed [49:0] px_next, py_next, pz_next;
    logic               pv_reg;
    logic signed [51:0] ax_reg, ay_reg, az_reg;
    logic signed [51:0] rx, ry, rz;
    logic signed [17:0] sw;

    assign sw      = $signed({1'b0, weight});
    assign px_next = 50'(sw * x);
    assign py_next = 50'(sw * y);
    assign pz_next = 50'(sw * z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= in_valid && !clear;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        pz_reg <= pz_next;
        if (clear)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
        end
        else if (pv_reg)
        begin
            ax_reg <= ax_reg + 52'(px_reg);
            ay_reg <= ay_reg + 52'(py_reg);
            az_reg <= az_reg + 52'(pz_reg);
        end
    end

    // round to nearest, ties up, then drop 16 fraction bits
    assign rx    = ax_reg + 52'sd32768;
    assign ry    = ay_reg + 52'sd32768;
    assign rz    = az_reg + 52'sd32768;
    assign res_x = rx[47:16];
    assign res_y = ry[47:16];
    assign res_z = rz[47:16];

endmodule

/* design/tms_tables.sv */
// Mesh tables: vertex, triangle corner+color, triangle edge, edge end, edge tri.
// Depends on tms_pkg for the strobe struct. One write, one registered read each.
module tms_tables #(
    parameter int VERTEX_DEPTH   = tms_pkg::VERTEX_DEPTH_DEF,
    parameter int TRIANGLE_DEPTH = tms_pkg::TRIANGLE_DEPTH_DEF,
    parameter int EDGE_DEPTH     = tms_pkg::EDGE_DEPTH_DEF,
    localparam int VAW = $clog2(VERTEX_DEPTH),
    localparam int TAW = $clog2(TRIANGLE_DEPTH),
    localparam int EAW = $clog2(EDGE_DEPTH)
) (
    input  logic             clk,
    input  tms_pkg::tbl_ctl_t ctl,
    input  logic [VAW-1:0]   vtx_waddr,
    input  logic [VAW-1:0]   vtx_raddr,
    input  logic [95:0]      vtx_wdata,
    output logic [95:0]      vtx_rdata,
    input  logic [TAW-1:0]   tri_waddr,
    input  logic [TAW-1:0]   tri_raddr,
    input  logic [60:0]      tri_wdata,
    output logic [60:0]      tri_rdata,
    input  logic [TAW-1:0]   tedg_waddr,
    input  logic [TAW-1:0]   tedg_raddr,
    input  logic [44:0]      tedg_wdata,
    output logic [44:0]      tedg_rdata,
    input  logic [EAW-1:0]   eend_waddr,
    input  logic [EAW-1:0]   eend_raddr,
    input  logic [29:0]      eend_wdata,
    output logic [29:0]      eend_rdata,
    input  logic [EAW-1:0]   etri_waddr,
    input  logic [EAW-1:0]   etri_raddr,
    input  logic [29:0]      etri_wdata,
    output logic [29:0]      etri_rdata
);
    import tms_pkg::*;

    logic [95:0] vtx_mem  [VERTEX_DEPTH];
    logic [60:0] tri_mem  [TRIANGLE_DEPTH];
    logic [44:0] tedg_mem [TRIANGLE_DEPTH];
    logic [29:0] eend_mem [EDGE_DEPTH];
    logic [29:0] etri_mem [EDGE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.vtx_we)  vtx_mem[vtx_waddr]   <= vtx_wdata;
        if (ctl.vtx_re)  vtx_rdata            <= vtx_mem[vtx_raddr];
        if (ctl.tri_we)  tri_mem[tri_waddr]   <= tri_wdata;
        if (ctl.tri_re)  tri_rdata            <= tri_mem[tri_raddr];
        if (ctl.tedg_we) tedg_mem[tedg_waddr] <= tedg_wdata;
        if (ctl.tedg_re) tedg_rdata           <= tedg_mem[tedg_raddr];
        if (ctl.eend_we) eend_mem[eend_waddr] <= eend_wdata;
        if (ctl.eend_re) eend_rdata           <= eend_mem[eend_raddr];
        if (ctl.etri_we) etri_mem[etri_waddr] <= etri_wdata;
        if (ctl.etri_re) etri_rdata           <= etri_mem[etri_raddr];
    end

endmodule

/* design/triangle_mesh_point_split.sv */
// Top level of the triangle mesh point split: sequencer, counts, output register.
// Depends on tms_pkg, tms_tables and tms_blend.
//
//  channel | signals                     | transfer
//  --------+-----------------------------+-------------------------------
//  input   | in_valid, in_ready, in_item | item taken on valid & ready
//  output  | out_valid, out_ready, out_item | record taken on valid & ready
//  config  | cfg_we, cfg_index, cfg_data | register written on cfg_we
//
// Loads, count sets, undefined kinds and splits refused on counts or weights
// give one record, registered in the accept cycle and valid on the next.
// A split reads the triangle, runs the three corners through the blend unit,
// then emits 16 records with an edge-table read before each sub-triangle's
// five; a triangle with an out-of-range reference gives one error record
// instead. Output stalls hold the sequencer; no clearing pass.
module triangle_mesh_point_split #(
    parameter int VERTEX_DEPTH   = tms_pkg::VERTEX_DEPTH_DEF,
    parameter int TRIANGLE_DEPTH = tms_pkg::TRIANGLE_DEPTH_DEF,
    parameter int EDGE_DEPTH     = tms_pkg::EDGE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tms_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output tms_pkg::out_t out_item,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [16:0]   cfg_data
);
    import tms_pkg::*;

    localparam int VAW = $clog2(VERTEX_DEPTH);
    localparam int TAW = $clog2(TRIANGLE_DEPTH);
    localparam int EAW = $clog2(EDGE_DEPTH);
    localparam int VCW = $clog2(VERTEX_DEPTH + 1);
    localparam int TCW = $clog2(TRIANGLE_DEPTH + 1);
    localparam int ECW = $clog2(EDGE_DEPTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_RD_TRI   = 8'b00000010,
        ST_VRD      = 8'b00000100,
        ST_VWAIT    = 8'b00001000,
        ST_EMIT_V   = 8'b00010000,
        ST_ITER_RD  = 8'b00100000,
        ST_ITER_REC = 8'b01000000,
        ST_ERR      = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    in_t    item_reg, item_next;
    logic [16:0] bu_reg, bv_reg;
    logic [VCW-1:0] vcnt_reg, vcnt_next, nv_reg, nv_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next, tb_reg, tb_next;
    logic [ECW-1:0] ecnt_reg, ecnt_next, eb_reg, eb_next;
    logic [14:0] c_reg [3];
    logic [14:0] c_next [3];
    logic [14:0] e_reg [3];
    logic [14:0] e_next [3];
    logic [15:0] col_reg, col_next;
    logic [1:0]  vk_reg, vk_next, it_reg, it_next;
    logic [2:0]  rc_reg, rc_next;
    logic        out_valid_reg;
    out_t        out_item_reg;

    logic        slot_free, push;
    out_t        rec;
    tbl_ctl_t    ctl;
    logic [VAW-1:0] vtx_waddr, vtx_raddr;
    logic [TAW-1:0] tri_waddr, tri_raddr, tedg_waddr, tedg_raddr;
    logic [EAW-1:0] eend_waddr, eend_raddr, etri_waddr, etri_raddr;
    logic [95:0] vtx_wdata, vtx_rdata;
    logic [60:0] tri_wdata, tri_rdata;
    logic [44:0] tedg_wdata, tedg_rdata;
    logic [29:0] eend_wdata, eend_rdata, etri_wdata, etri_rdata;

    logic        bl_clear, bl_valid;
    logic [16:0] bl_weight, w_full;
    logic signed [31:0] res_x, res_y, res_z;

    logic [31:0] idx32, nt_w [3], ne_w [3];
    logic [1:0]  it_p1, it_p2;
    logic [17:0] uv_sum;
    logic        split_bad, tri_bad, swap;
    logic [14:0] ce, ea, eb, sa, sb, et0, et1, net0, net1, tref, ct15;

    tms_tables #(
        .VERTEX_DEPTH  (VERTEX_DEPTH),
        .TRIANGLE_DEPTH(TRIANGLE_DEPTH),
        .EDGE_DEPTH    (EDGE_DEPTH)
    ) u_tables (
        .clk(clk), .ctl(ctl),
        .vtx_waddr(vtx_waddr), .vtx_raddr(vtx_raddr),
        .vtx_wdata(vtx_wdata), .vtx_rdata(vtx_rdata),
        .tri_waddr(tri_waddr), .tri_raddr(tri_raddr),
        .tri_wdata(tri_wdata), .tri_rdata(tri_rdata),
        .tedg_waddr(tedg_waddr), .tedg_raddr(tedg_raddr),
        .tedg_wdata(tedg_wdata), .tedg_rdata(tedg_rdata),
        .eend_waddr(eend_waddr), .eend_raddr(eend_raddr),
        .eend_wdata(eend_wdata), .eend_rdata(eend_rdata),
        .etri_waddr(etri_waddr), .etri_raddr(etri_raddr),
        .etri_wdata(etri_wdata), .etri_rdata(etri_rdata)
    );

    tms_blend u_blend (
        .clk(clk), .rst_n(rst_n), .clear(bl_clear), .in_valid(bl_valid),
        .weight(bl_weight),
        .x(vtx_rdata[95:64]), .y(vtx_rdata[63:32]), .z(vtx_rdata[31:0]),
        .res_x(res_x), .res_y(res_y), .res_z(res_z)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // split bookkeeping
    assign idx32  = 32'(in_item.entry_index);
    assign uv_sum = {1'b0, bu_reg} + {1'b0, bv_reg};
    assign w_full = 17'(18'd65536 - uv_sum);
    assign split_bad = (uv_sum > 18'd65536) || (idx32 >= 32'(tcnt_reg))
                    || (32'(vcnt_reg) >= VERTEX_DEPTH)
                    || (32'(tcnt_reg) + 32'd2 > TRIANGLE_DEPTH)
                    || (32'(ecnt_reg) + 32'd3 > EDGE_DEPTH);
    assign tri_bad = (32'(tri_rdata[60:46]) >= VERTEX_DEPTH)
                  || (32'(tri_rdata[45:31]) >= VERTEX_DEPTH)
                  || (32'(tri_rdata[30:16]) >= VERTEX_DEPTH)
                  || (32'(tedg_rdata[44:30]) >= EDGE_DEPTH)
                  || (32'(tedg_rdata[29:15]) >= EDGE_DEPTH)
                  || (32'(tedg_rdata[14:0]) >= EDGE_DEPTH);

    assign nt_w[0] = 32'(tb_reg);
    assign nt_w[1] = 32'(tb_reg) + 32'd1;
    assign nt_w[2] = 32'(item_reg.entry_index);
    assign ne_w[0] = 32'(eb_reg);
    assign ne_w[1] = 32'(eb_reg) + 32'd1;
    assign ne_w[2] = 32'(eb_reg) + 32'd2;
    assign it_p1   = (it_reg == 2'd2) ? 2'd0 : 2'(it_reg + 2'd1);
    assign it_p2   = (it_reg == 2'd0) ? 2'd2 : 2'(it_reg - 2'd1);

    // old edge of this sub-triangle, oriented to follow the corner order
    assign ce   = e_reg[it_reg];
    assign ea   = eend_rdata[29:15];
    assign eb   = eend_rdata[14:0];
    assign swap = (ea == c_reg[0] && eb != c_reg[1])
               || (ea == c_reg[1] && eb != c_reg[2])
               || (ea == c_reg[2] && eb != c_reg[0]);
    assign sa   = swap ? eb : ea;
    assign sb   = swap ? ea : eb;
    assign tref = 15'(nt_w[it_reg]);
    assign ct15 = {1'b0, item_reg.entry_index};
    assign et0  = etri_rdata[29:15];
    assign et1  = etri_rdata[14:0];
    // a boundary edge keeps its lone neighbor in the first slot
    assign net0 = (et1 == NONE_REF || et0 == ct15) ? tref : et0;
    assign net1 = (et1 != NONE_REF && et1 == ct15) ? tref : et1;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        vcnt_next  = vcnt_reg;
        tcnt_next  = tcnt_reg;
        ecnt_next  = ecnt_reg;
        nv_next    = nv_reg;
        tb_next    = tb_reg;
        eb_next    = eb_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        col_next   = col_reg;
        vk_next    = vk_reg;
        it_next    = it_reg;
        rc_next    = rc_reg;
        push       = 1'b0;
        rec        = '0;
        ctl        = '0;
        vtx_waddr  = '0;
        vtx_raddr  = '0;
        vtx_wdata  = '0;
        tri_waddr  = '0;
        tri_raddr  = '0;
        tri_wdata  = '0;
        tedg_waddr = '0;
        tedg_raddr = '0;
        tedg_wdata = '0;
        eend_waddr = '0;
        eend_raddr = '0;
        eend_wdata = '0;
        etri_waddr = '0;
        etri_raddr = '0;
        etri_wdata = '0;
        bl_clear   = 1'b0;
        bl_valid   = 1'b0;
        bl_weight  = w_full;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next          = in_item;
                    rec.record_index   = in_item.entry_index;
                    rec.last           = 1'b1;
                    rec.record_kind    = REC_ACK;
                    push               = 1'b1;
                    case (in_item.kind)
                        KIND_VERTEX:
                        begin
                            if (idx32 >= VERTEX_DEPTH)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                ctl.vtx_we = 1'b1;
                                vtx_waddr  = VAW'(in_item.entry_index);
                                vtx_wdata  = {in_item.coord_x, in_item.coord_y,
                                              in_item.coord_z};
                            end
                        end
                        KIND_TRI_CORNER:
                        begin
                            if (idx32 >= TRIANGLE_DEPTH)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                ctl.tri_we = 1'b1;
                                tri_waddr  = TAW'(in_item.entry_index);
                                tri_wdata  = {in_item.ref_first, in_item.ref_second,
                                              in_item.ref_third, in_item.color};
                            end
                        end
                        KIND_TRI_EDGE:
                        begin
                            if (idx32 >= TRIANGLE_DEPTH)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                ctl.tedg_we = 1'b1;
                                tedg_waddr  = TAW'(in_item.entry_index);
                                tedg_wdata  = {in_item.ref_first, in_item.ref_second,
                                               in_item.ref_third};
                            end
                        end
                        KIND_EDGE_END:
                        begin
                            if (idx32 >= EDGE_DEPTH)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                ctl.eend_we = 1'b1;
                                eend_waddr  = EAW'(in_item.entry_index);
                                eend_wdata  = {in_item.ref_first, in_item.ref_second};
                            end
                        end
                        KIND_EDGE_TRI:
                        begin
                            if (idx32 >= EDGE_DEPTH)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                ctl.etri_we = 1'b1;
                                etri_waddr  = EAW'(in_item.entry_index);
                                etri_wdata  = {in_item.ref_first, in_item.ref_second};
                            end
                        end
                        KIND_SET_COUNTS:
                        begin
                            vcnt_next = (32'(in_item.ref_first) > VERTEX_DEPTH)
                                      ? VCW'(VERTEX_DEPTH) : VCW'(in_item.ref_first);
                            tcnt_next = (32'(in_item.ref_second) > TRIANGLE_DEPTH)
                                      ? TCW'(TRIANGLE_DEPTH) : TCW'(in_item.ref_second);
                            ecnt_next = (32'(in_item.ref_third) > EDGE_DEPTH)
                                      ? ECW'(EDGE_DEPTH) : ECW'(in_item.ref_third);
                        end
                        KIND_SPLIT:
                        begin
                            if (split_bad)
                                rec.record_kind = REC_ERROR;
                            else
                            begin
                                push        = 1'b0;
                                ctl.tri_re  = 1'b1;
                                ctl.tedg_re = 1'b1;
                                tri_raddr   = TAW'(in_item.entry_index);
                                tedg_raddr  = TAW'(in_item.entry_index);
                                state_next  = ST_RD_TRI;
                            end
                        end
                        default:
                        begin
                            rec.record_kind = REC_ERROR;
                        end
                    endcase
                end
            end
            ST_RD_TRI:
            begin
                c_next[0] = tri_rdata[60:46];
                c_next[1] = tri_rdata[45:31];
                c_next[2] = tri_rdata[30:16];
                col_next  = tri_rdata[15:0];
                e_next[0] = tedg_rdata[44:30];
                e_next[1] = tedg_rdata[29:15];
                e_next[2] = tedg_rdata[14:0];
                nv_next   = vcnt_reg;
                tb_next   = tcnt_reg;
                eb_next   = ecnt_reg;
                vk_next   = 2'd0;
                bl_clear  = 1'b1;
                if (tri_bad)
                    state_next = ST_ERR;
                else
                begin
                    ctl.vtx_re = 1'b1;
                    vtx_raddr  = VAW'(tri_rdata[60:46]);
                    state_next = ST_VRD;
                end
            end
            ST_VRD:
            begin
                bl_valid = 1'b1;
                case (vk_reg)
                    2'd0:    bl_weight = w_full;
                    2'd1:    bl_weight = bu_reg;
                    default: bl_weight = bv_reg;
                endcase
                if (vk_reg != 2'd2)
                begin
                    ctl.vtx_re = 1'b1;
                    vtx_raddr  = VAW'(c_reg[2'(vk_reg + 2'd1)]);
                    vk_next    = 2'(vk_reg + 2'd1);
                end
                else
                    state_next = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                state_next = ST_EMIT_V;
            end
            ST_EMIT_V:
            begin
                if (slot_free)
                begin
                    push             = 1'b1;
                    rec.record_kind  = REC_VERTEX;
                    rec.record_index = 14'(nv_reg);
                    rec.out_x        = res_x;
                    rec.out_y        = res_y;
                    rec.out_z        = res_z;
                    ctl.vtx_we       = 1'b1;
                    vtx_waddr        = VAW'(nv_reg);
                    vtx_wdata        = {res_x, res_y, res_z};
                    vcnt_next        = VCW'(vcnt_reg + 1'b1);
                    tcnt_next        = TCW'(tcnt_reg + 2'd2);
                    ecnt_next        = ECW'(ecnt_reg + 2'd3);
                    it_next          = 2'd0;
                    state_next       = ST_ITER_RD;
                end
            end
            ST_ITER_RD:
            begin
                ctl.eend_re = 1'b1;
                ctl.etri_re = 1'b1;
                eend_raddr  = EAW'(ce);
                etri_raddr  = EAW'(ce);
                rc_next     = 3'd0;
                state_next  = ST_ITER_REC;
            end
            ST_ITER_REC:
            begin
                if (slot_free)
                begin
                    push = 1'b1;
                    case (rc_reg)
                        3'd0:
                        begin
                            rec.record_kind    = REC_TRI_CORNER;
                            rec.record_index   = 14'(nt_w[it_reg]);
                            rec.out_ref_first  = sa;
                            rec.out_ref_second = sb;
                            rec.out_ref_third  = 15'(nv_reg);
                            rec.out_color      = col_reg;
                            ctl.tri_we         = 1'b1;
                            tri_waddr          = TAW'(nt_w[it_reg]);
                            tri_wdata          = {sa, sb, 15'(nv_reg), col_reg};
                        end
                        3'd1:
                        begin
                            rec.record_kind    = REC_TRI_EDGE;
                            rec.record_index   = 14'(nt_w[it_reg]);
                            rec.out_ref_first  = ce;
                            rec.out_ref_second = 15'(ne_w[it_reg]);
                            rec.out_ref_third  = 15'(ne_w[it_p2]);
                            ctl.tedg_we        = 1'b1;
                            tedg_waddr         = TAW'(nt_w[it_reg]);
                            tedg_wdata         = {ce, 15'(ne_w[it_reg]), 15'(ne_w[it_p2])};
                        end
                        3'd2:
                        begin
                            rec.record_kind    = REC_EDGE_END;
                            rec.record_index   = 14'(ne_w[it_reg]);
                            rec.out_ref_first  = sb;
                            rec.out_ref_second = 15'(nv_reg);
                            ctl.eend_we        = 1'b1;
                            eend_waddr         = EAW'(ne_w[it_reg]);
                            eend_wdata         = {sb, 15'(nv_reg)};
                        end
                        3'd3:
                        begin
                            rec.record_kind    = REC_EDGE_TRI;
                            rec.record_index   = 14'(ce);
                            rec.out_ref_first  = net0;
                            rec.out_ref_second = net1;
                            ctl.etri_we        = 1'b1;
                            etri_waddr         = EAW'(ce);
                            etri_wdata         = {net0, net1};
                        end
                        default:
                        begin
                            rec.record_kind    = REC_EDGE_TRI;
                            rec.record_index   = 14'(ne_w[it_reg]);
                            rec.out_ref_first  = 15'(nt_w[it_p1]);
                            rec.out_ref_second = tref;
                            ctl.etri_we        = 1'b1;
                            etri_waddr         = EAW'(ne_w[it_reg]);
                            etri_wdata         = {15'(nt_w[it_p1]), tref};
                        end
                    endcase
                    rc_next = 3'(rc_reg + 3'd1);
                    if (rc_reg == 3'd4)
                    begin
                        if (it_reg == 2'd2)
                        begin
                            rec.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            it_next    = 2'(it_reg + 2'd1);
                            state_next = ST_ITER_RD;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    push             = 1'b1;
                    rec.record_kind  = REC_ERROR;
                    rec.record_index = item_reg.entry_index;
                    rec.last         = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcnt_reg      <= '0;
            tcnt_reg      <= '0;
            ecnt_reg      <= '0;
            bu_reg        <= BARY_RESET;
            bv_reg        <= BARY_RESET;
            out_valid_reg <= 1'b0;
            vk_reg        <= '0;
            it_reg        <= '0;
            rc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vcnt_reg      <= vcnt_next;
            tcnt_reg      <= tcnt_next;
            ecnt_reg      <= ecnt_next;
            vk_reg        <= vk_next;
            it_reg        <= it_next;
            rc_reg        <= rc_next;
            out_valid_reg <= push || (out_valid_reg && !out_ready);
            if (cfg_we && cfg_index == CFG_BARY_U) bu_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_BARY_V) bv_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        nv_reg   <= nv_next;
        tb_reg   <= tb_next;
        eb_reg   <= eb_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        col_reg  <= col_next;
        if (push)
            out_item_reg <= rec;
    end

    a_rc_range: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= 3'd5)
        else $error("record step out of range");

    a_it_range: assert property (@(posedge clk) disable iff (!rst_n)
        it_reg <= 2'd2)
        else $error("sub-triangle step out of range");

    a_vcnt_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_V && slot_free)
        |=> vcnt_reg == VCW'($past(vcnt_reg) + 1'b1))
        else $error("vertex count not bumped on split");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && rec.last && state_reg == ST_ITER_REC) |=> state_reg == ST_IDLE)
        else $error("split did not return to idle after final record");

    a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !push)
        else $error("record pushed into a full output slot");

endmodule
